// ----- src/mcas_pkg.sv -----
// ============================================================================
// Min-cost assignment solver package
// Shared widths, solver state encoding, flag bundle of the shared ALU and a
// sign-extension helper.
// ============================================================================
`default_nettype none

package mcas_pkg;

  localparam int MAX_N_DEF = 64;   // default largest matrix dimension
  localparam int CE_W      = 31;   // width of one loaded cost entry
  localparam int WW        = 32;   // width of a stored (reduced) matrix entry
  localparam int DW        = 44;   // width of duals, slacks and sums
  localparam int TOT_W     = 37;   // width of the reported total cost
  localparam int IDX_W     = 6;    // width of the reported row and column
  localparam int CFG_W     = 7;    // width of the size register

  localparam logic signed [DW-1:0] SLACK_INF = {{(DW-40){1'b0}}, {40{1'b1}}};

  typedef struct packed {
    logic lt;     // result is below operand d
    logic zero;   // result is zero
  } alu_flags_t;

  typedef enum logic [5:0] {
    ST_LOAD,
    ST_CM_RD,  ST_CM_EX,  ST_CM_SUM, ST_CW_RD,  ST_CW_EX,
    ST_CI,
    ST_RM_RD,  ST_RM_EX,  ST_GR_RD,  ST_GR_EX,
    ST_SQ,     ST_SP,     ST_SR,     ST_SC_RD,  ST_SC_EX,
    ST_MN_RD,  ST_MN_EX,
    ST_RU_Q,   ST_RU_P,   ST_RU_EX,
    ST_SU_RD,  ST_SU_EX,  ST_IC_RD,  ST_IC_EX,
    ST_AU_RD,  ST_AU_EX,  ST_AU_P,
    ST_RS_RD,  ST_RS_EX,  ST_RP_RD,  ST_RP_EX,
    ST_FR_RD,  ST_FR,     ST_F1_RD,  ST_F1_EX,
    ST_TC_RD,  ST_TC_EX,
    ST_O_RD,   ST_O_EX
  } state_e;

  function automatic logic signed [DW-1:0] sext_w(input logic signed [WW-1:0] x);
    return {{(DW-WW){x[WW-1]}}, x};
  endfunction

endpackage

`default_nettype wire

// ----- src/mcas_alu.sv -----
// ============================================================================
// Min-cost assignment solver ALU
// Shared add/subtract/compare unit: res = a - b + c, compared against d.
// ============================================================================
`default_nettype none

module mcas_alu (
  input  logic signed [mcas_pkg::DW-1:0] a_i,
  input  logic signed [mcas_pkg::DW-1:0] b_i,
  input  logic signed [mcas_pkg::DW-1:0] c_i,
  input  logic signed [mcas_pkg::DW-1:0] d_i,
  output logic signed [mcas_pkg::DW-1:0] res_o,
  output mcas_pkg::alu_flags_t           flags_o
);
  import mcas_pkg::*;

  assign res_o        = a_i - b_i + c_i;
  assign flags_o.lt   = (res_o < d_i);
  assign flags_o.zero = (res_o == '0);

endmodule

`default_nettype wire

// ----- src/min_cost_assignment_solver_unit.sv -----
// ============================================================================
// Min-cost assignment solver
// Loads an N x N cost matrix and solves it with the Hungarian method on one
// shared ALU, then reports one assignment per row.
// ============================================================================
// Loading takes one cost entry per cycle; after the last entry the input stalls
// until the last of the N results has been placed in the output register.
// The solve shares one add/compare unit over registered-read memories with separate
// read and write ports for the reductions, greedy matching, forest search and final
// check. Results leave one per row, each read and then registered, unless stalled.
// Reset (asynchronous, active low) sets N to 64, or to MAX_N if that is smaller,
// and clears control state.
`default_nettype none

module min_cost_assignment_solver_unit #(
  parameter int MAX_N = mcas_pkg::MAX_N_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mcas_pkg::CFG_W-1:0]        cfg_matrix_size_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mcas_pkg::CE_W-1:0]  cost_entry_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mcas_pkg::IDX_W-1:0]        row_index_o,
  output logic [mcas_pkg::IDX_W-1:0]        assigned_column_o,
  output logic signed [mcas_pkg::TOT_W-1:0] total_cost_o,
  output logic                              check_failed_o,
  output logic                              last_result_o
);
  import mcas_pkg::*;

  localparam int NW = $clog2(MAX_N);
  localparam int CW = $clog2(MAX_N + 1);
  localparam int AW = $clog2(MAX_N * MAX_N);
  localparam int PW = NW + 1;
  localparam logic [PW-1:0] NONE = {1'b1, {NW{1'b0}}};

  typedef struct packed {
    logic [PW-1:0]          partner;
    logic [PW-1:0]          parent;
    logic signed [DW-1:0]   inc;
    logic signed [DW-1:0]   slack;
    logic [NW-1:0]          src;
  } col_t;

  typedef struct packed {
    logic signed [DW-1:0]   red;
    logic [PW-1:0]          partner;
  } row_t;

  // Memories with registered reads.
  logic signed [WW-1:0] cost_mem [MAX_N*MAX_N];
  col_t                 col_mem  [MAX_N];
  row_t                 row_mem  [MAX_N];
  logic [NW-1:0]        pend_mem [MAX_N];

  logic signed [WW-1:0] cm_rd_q;
  col_t                 col_rd_q;
  row_t                 row_rd_q;
  logic [NW-1:0]        pend_rd_q;

  logic [AW-1:0]        cm_raddr, cm_waddr, rc_addr;
  logic                 cm_we;
  logic signed [WW-1:0] cm_wdata;
  logic [NW-1:0]        col_raddr, col_waddr;
  logic                 col_we;
  col_t                 col_wdata;
  logic [NW-1:0]        row_raddr, row_waddr;
  logic                 row_we;
  row_t                 row_wdata;
  logic [NW-1:0]        pend_raddr, pend_waddr;
  logic                 pend_we;
  logic [NW-1:0]        pend_wdata;

  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      cost_mem[cm_waddr] <= cm_wdata;
    end
    cm_rd_q <= cost_mem[cm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rd_q <= col_mem[col_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rd_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    pend_rd_q <= pend_mem[pend_raddr];
  end

  // Shared ALU.
  logic signed [DW-1:0] alu_a, alu_b, alu_c, alu_d, alu_res;
  alu_flags_t           alu_f;

  mcas_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .c_i     (alu_c),
    .d_i     (alu_d),
    .res_o   (alu_res),
    .flags_o (alu_f)
  );

  // Control and working registers.
  state_e               state_q, state_d;
  logic [CW-1:0]        n_q, n_d;
  logic [AW-1:0]        ld_q, ld_d;
  logic [NW-1:0]        r_q, r_d, c_q, c_d, ar_q, ar_d, ac_q, ac_d, prev_q, prev_d;
  logic [CW-1:0]        q_q, q_d, t_q, t_d, unm_q, unm_d;
  logic [CW:0]          guard_q, guard_d;
  logic signed [DW-1:0] s_q, s_d, red_q, red_d, base_q, base_d, tot_q, tot_d;
  logic signed [WW-1:0] mn_q, mn_d;
  logic [PW-1:0]        pp_q, pp_d;
  logic                 fail_q, fail_d;

  logic                 out_valid_q, out_valid_d;
  logic [IDX_W-1:0]     out_row_q, out_row_d, out_col_q, out_col_d;
  logic signed [TOT_W-1:0] out_tot_q, out_tot_d;
  logic                 out_fail_q, out_fail_d, out_last_q, out_last_d;

  logic                 in_acc, cfg_acc, out_free, c_last, r_last, go_fin, next_row;
  logic [CW-1:0]        cfg_n, t_nx;
  logic [AW-1:0]        nn_m1;
  logic signed [DW-1:0] wk, s_nx;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign rc_addr = AW'(r_q) * AW'(n_q) + AW'(c_q);
  assign nn_m1   = AW'(n_q) * AW'(n_q) - AW'(1);
  assign c_last  = (CW'(c_q) == n_q - CW'(1));
  assign r_last  = (CW'(r_q) == n_q - CW'(1));
  assign wk      = sext_w(cm_rd_q);

  always_comb begin
    if (cfg_matrix_size_i == '0) begin
      cfg_n = CW'(1);
    end else if (int'(cfg_matrix_size_i) > MAX_N) begin
      cfg_n = CW'(MAX_N);
    end else begin
      cfg_n = CW'(cfg_matrix_size_i);
    end
  end

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    ld_d    = ld_q;
    r_d     = r_q;
    c_d     = c_q;
    ar_d    = ar_q;
    ac_d    = ac_q;
    prev_d  = prev_q;
    q_d     = q_q;
    t_d     = t_q;
    unm_d   = unm_q;
    guard_d = guard_q;
    s_d     = s_q;
    red_d   = red_q;
    base_d  = base_q;
    tot_d   = tot_q;
    mn_d    = mn_q;
    pp_d    = pp_q;
    fail_d  = fail_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_tot_d   = out_tot_q;
    out_fail_d  = out_fail_q;
    out_last_d  = out_last_q;

    cm_raddr   = rc_addr;
    cm_waddr   = rc_addr;
    cm_we      = 1'b0;
    cm_wdata   = alu_res[WW-1:0];
    col_raddr  = c_q;
    col_waddr  = c_q;
    col_we     = 1'b0;
    col_wdata  = col_rd_q;
    row_raddr  = r_q;
    row_waddr  = r_q;
    row_we     = 1'b0;
    row_wdata  = row_rd_q;
    pend_raddr = q_q[NW-1:0];
    pend_waddr = t_q[NW-1:0];
    pend_we    = 1'b0;
    pend_wdata = r_q;

    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    alu_d = '0;

    go_fin   = 1'b0;
    next_row = 1'b0;
    t_nx     = t_q;
    s_nx     = s_q;

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          cm_we    = 1'b1;
          cm_waddr = ld_q;
          cm_wdata = {cost_entry_i[CE_W-1], cost_entry_i};
          if (ld_q == nn_m1) begin
            ld_d    = '0;
            r_d     = '0;
            c_d     = '0;
            base_d  = '0;
            fail_d  = 1'b0;
            state_d = ST_CM_RD;
          end else begin
            ld_d = ld_q + AW'(1);
          end
        end
      end

      // Column minimum and reduction.
      ST_CM_RD: state_d = ST_CM_EX;
      ST_CM_EX: begin
        alu_a = wk;
        alu_d = sext_w(mn_q);
        if (r_q == '0 || alu_f.lt) begin
          mn_d = cm_rd_q;
        end
        if (r_last) begin
          r_d     = '0;
          state_d = ST_CM_SUM;
        end else begin
          r_d     = r_q + NW'(1);
          state_d = ST_CM_RD;
        end
      end
      ST_CM_SUM: begin
        alu_a   = base_q;
        alu_c   = sext_w(mn_q);
        base_d  = alu_res;
        state_d = ST_CW_RD;
      end
      ST_CW_RD: state_d = ST_CW_EX;
      ST_CW_EX: begin
        alu_a = wk;
        alu_b = sext_w(mn_q);
        cm_we = 1'b1;
        if (r_last) begin
          r_d = '0;
          if (c_last) begin
            c_d     = '0;
            state_d = ST_CI;
          end else begin
            c_d     = c_q + NW'(1);
            state_d = ST_CM_RD;
          end
        end else begin
          r_d     = r_q + NW'(1);
          state_d = ST_CW_RD;
        end
      end

      ST_CI: begin
        col_we            = 1'b1;
        col_wdata.partner = NONE;
        col_wdata.parent  = NONE;
        col_wdata.inc     = '0;
        col_wdata.slack   = SLACK_INF;
        col_wdata.src     = '0;
        if (c_last) begin
          c_d     = '0;
          r_d     = '0;
          t_d     = '0;
          state_d = ST_RM_RD;
        end else begin
          c_d = c_q + NW'(1);
        end
      end

      // Row minimum and greedy matching.
      ST_RM_RD: state_d = ST_RM_EX;
      ST_RM_EX: begin
        alu_a = wk;
        alu_d = s_q;
        if (c_q == '0 || alu_f.lt) begin
          s_d = wk;
        end
        if (c_last) begin
          c_d     = '0;
          state_d = ST_GR_RD;
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_RM_RD;
        end
      end
      ST_GR_RD: state_d = ST_GR_EX;
      ST_GR_EX: begin
        alu_a         = wk;
        alu_b         = s_q;
        row_wdata.red = s_q;
        if (alu_f.zero && col_rd_q.partner[NW]) begin
          col_we            = 1'b1;
          col_wdata.partner = {1'b0, r_q};
          row_we            = 1'b1;
          row_wdata.partner = {1'b0, c_q};
          next_row          = 1'b1;
        end else if (c_last) begin
          row_we            = 1'b1;
          row_wdata.partner = NONE;
          pend_we           = 1'b1;
          pend_wdata        = r_q;
          t_nx              = t_q + CW'(1);
          t_d               = t_nx;
          next_row          = 1'b1;
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_GR_RD;
        end
        if (next_row) begin
          c_d = '0;
          if (r_last) begin
            r_d = '0;
            if (t_nx == '0) begin
              go_fin = 1'b1;
            end else begin
              unm_d   = t_nx;
              q_d     = '0;
              state_d = ST_SQ;
            end
          end else begin
            r_d     = r_q + NW'(1);
            state_d = ST_RM_RD;
          end
        end
      end

      // Forest search: scan each pending row against all columns.
      ST_SQ: begin
        if (q_q < t_q) begin
          state_d = ST_SP;
        end else begin
          s_d     = SLACK_INF;
          c_d     = '0;
          state_d = ST_MN_RD;
        end
      end
      ST_SP: begin
        row_raddr = pend_rd_q;
        r_d       = pend_rd_q;
        state_d   = ST_SR;
      end
      ST_SR: begin
        red_d   = row_rd_q.red;
        c_d     = '0;
        state_d = ST_SC_RD;
      end
      ST_SC_RD: state_d = ST_SC_EX;
      ST_SC_EX: begin
        alu_a = wk;
        alu_b = red_q;
        alu_c = col_rd_q.inc;
        alu_d = col_rd_q.slack;
        if (c_last) begin
          q_d     = q_q + CW'(1);
          state_d = ST_SQ;
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_SC_RD;
        end
        if (col_rd_q.slack != '0 && alu_f.lt) begin
          if (alu_f.zero) begin
            if (col_rd_q.partner[NW]) begin
              ar_d    = r_q;
              ac_d    = c_q;
              guard_d = '0;
              q_d     = q_q;
              c_d     = c_q;
              state_d = ST_AU_RD;
            end else begin
              col_we           = 1'b1;
              col_wdata.slack  = '0;
              col_wdata.parent = {1'b0, r_q};
              if (t_q == CW'(MAX_N)) begin
                fail_d = 1'b1;
                go_fin = 1'b1;
              end else begin
                pend_we    = 1'b1;
                pend_wdata = col_rd_q.partner[NW-1:0];
                t_d        = t_q + CW'(1);
              end
            end
          end else begin
            col_we          = 1'b1;
            col_wdata.slack = alu_res;
            col_wdata.src   = r_q;
          end
        end
      end

      // Smallest nonzero slack.
      ST_MN_RD: state_d = ST_MN_EX;
      ST_MN_EX: begin
        alu_a = col_rd_q.slack;
        alu_d = s_q;
        if (col_rd_q.slack != '0 && alu_f.lt) begin
          s_nx = col_rd_q.slack;
        end
        s_d = s_nx;
        if (c_last) begin
          c_d = '0;
          if (s_nx == SLACK_INF) begin
            fail_d = 1'b1;
            go_fin = 1'b1;
          end else begin
            q_d     = '0;
            state_d = ST_RU_Q;
          end
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_MN_RD;
        end
      end

      // Raise the duals of all forest rows.
      ST_RU_Q: begin
        if (q_q < t_q) begin
          state_d = ST_RU_P;
        end else begin
          c_d     = '0;
          state_d = ST_SU_RD;
        end
      end
      ST_RU_P: begin
        row_raddr = pend_rd_q;
        r_d       = pend_rd_q;
        state_d   = ST_RU_EX;
      end
      ST_RU_EX: begin
        alu_a         = row_rd_q.red;
        alu_c         = s_q;
        row_we        = 1'b1;
        row_wdata.red = alu_res;
        q_d           = q_q + CW'(1);
        state_d       = ST_RU_Q;
      end

      // Lower the slacks; a column reaching zero joins the forest.
      ST_SU_RD: state_d = ST_SU_EX;
      ST_SU_EX: begin
        col_we = 1'b1;
        if (c_last) begin
          c_d     = '0;
          state_d = ST_SQ;
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_SU_RD;
        end
        if (col_rd_q.slack != '0) begin
          alu_a           = col_rd_q.slack;
          alu_b           = s_q;
          col_wdata.slack = alu_res;
          if (alu_f.zero) begin
            if (col_rd_q.partner[NW]) begin
              ar_d    = col_rd_q.src;
              ac_d    = c_q;
              guard_d = '0;
              if (c_last) begin
                state_d = ST_AU_RD;
              end else begin
                state_d = ST_IC_RD;
              end
            end else begin
              col_wdata.parent = {1'b0, col_rd_q.src};
              if (t_q == CW'(MAX_N)) begin
                fail_d = 1'b1;
                go_fin = 1'b1;
              end else begin
                pend_we    = 1'b1;
                pend_wdata = col_rd_q.partner[NW-1:0];
                t_d        = t_q + CW'(1);
              end
            end
          end
        end else begin
          alu_a         = col_rd_q.inc;
          alu_c         = s_q;
          col_wdata.inc = alu_res;
        end
      end

      // Remaining tight columns after the augmenting column still get the step.
      ST_IC_RD: state_d = ST_IC_EX;
      ST_IC_EX: begin
        alu_a = col_rd_q.inc;
        alu_c = s_q;
        if (col_rd_q.slack == '0) begin
          col_we        = 1'b1;
          col_wdata.inc = alu_res;
        end
        if (c_last) begin
          state_d = ST_AU_RD;
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_IC_RD;
        end
      end

      // Flip the augmenting path.
      ST_AU_RD: begin
        row_raddr = ar_q;
        col_raddr = ac_q;
        state_d   = ST_AU_EX;
      end
      ST_AU_EX: begin
        row_we            = 1'b1;
        row_waddr         = ar_q;
        row_wdata.partner = {1'b0, ac_q};
        col_we            = 1'b1;
        col_waddr         = ac_q;
        col_wdata.partner = {1'b0, ar_q};
        col_raddr         = row_rd_q.partner[NW-1:0];
        if (row_rd_q.partner[NW]) begin
          unm_d = unm_q - CW'(1);
          if (unm_q == CW'(1)) begin
            go_fin = 1'b1;
          end else begin
            t_d     = '0;
            c_d     = '0;
            state_d = ST_RS_RD;
          end
        end else begin
          prev_d  = row_rd_q.partner[NW-1:0];
          state_d = ST_AU_P;
        end
      end
      ST_AU_P: begin
        guard_d = guard_q + (CW+1)'(1);
        if (col_rd_q.parent[NW] || (guard_q + (CW+1)'(1)) > {1'b0, n_q}) begin
          fail_d = 1'b1;
          go_fin = 1'b1;
        end else begin
          ar_d    = col_rd_q.parent[NW-1:0];
          ac_d    = prev_q;
          state_d = ST_AU_RD;
        end
      end

      // Start a new phase: clear the forest and collect free rows.
      ST_RS_RD: state_d = ST_RS_EX;
      ST_RS_EX: begin
        col_we           = 1'b1;
        col_wdata.parent = NONE;
        col_wdata.slack  = SLACK_INF;
        if (c_last) begin
          c_d     = '0;
          r_d     = '0;
          state_d = ST_RP_RD;
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_RS_RD;
        end
      end
      ST_RP_RD: state_d = ST_RP_EX;
      ST_RP_EX: begin
        if (row_rd_q.partner[NW]) begin
          pend_we    = 1'b1;
          pend_wdata = r_q;
          t_d        = t_q + CW'(1);
        end
        if (r_last) begin
          r_d     = '0;
          q_d     = '0;
          state_d = ST_SQ;
        end else begin
          r_d     = r_q + NW'(1);
          state_d = ST_RP_RD;
        end
      end

      // Dual feasibility and tightness check, plus row part of the total.
      ST_FR_RD: state_d = ST_FR;
      ST_FR: begin
        red_d = row_rd_q.red;
        pp_d  = row_rd_q.partner;
        if (row_rd_q.partner[NW]) begin
          fail_d = 1'b1;
        end
        alu_a   = tot_q;
        alu_c   = row_rd_q.red;
        tot_d   = alu_res;
        c_d     = '0;
        state_d = ST_F1_RD;
      end
      ST_F1_RD: state_d = ST_F1_EX;
      ST_F1_EX: begin
        alu_a = wk;
        alu_b = red_q;
        alu_c = col_rd_q.inc;
        if (alu_f.lt) begin
          fail_d = 1'b1;
        end
        if (!pp_q[NW] && pp_q[NW-1:0] == c_q && !alu_f.zero) begin
          fail_d = 1'b1;
        end
        if (c_last) begin
          c_d = '0;
          if (r_last) begin
            r_d     = '0;
            state_d = ST_TC_RD;
          end else begin
            r_d     = r_q + NW'(1);
            state_d = ST_FR_RD;
          end
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_F1_RD;
        end
      end

      ST_TC_RD: state_d = ST_TC_EX;
      ST_TC_EX: begin
        alu_a = tot_q;
        alu_b = col_rd_q.inc;
        tot_d = alu_res;
        if (c_last) begin
          c_d     = '0;
          r_d     = '0;
          state_d = ST_O_RD;
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_TC_RD;
        end
      end

      // One result per row.
      ST_O_RD: state_d = ST_O_EX;
      ST_O_EX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_row_d   = IDX_W'(r_q);
          out_col_d   = row_rd_q.partner[NW] ? '0 : IDX_W'(row_rd_q.partner[NW-1:0]);
          out_tot_d   = tot_q[TOT_W-1:0];
          out_fail_d  = fail_q;
          out_last_d  = r_last;
          if (r_last) begin
            r_d     = '0;
            state_d = ST_LOAD;
          end else begin
            r_d     = r_q + NW'(1);
            state_d = ST_O_RD;
          end
        end
      end

      default: state_d = ST_LOAD;
    endcase

    if (go_fin) begin
      r_d     = '0;
      c_d     = '0;
      tot_d   = base_q;
      state_d = ST_FR_RD;
    end

    if (cfg_acc) begin
      n_d  = cfg_n;
      ld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      n_q         <= CW'(MAX_N_DEF > MAX_N ? MAX_N : MAX_N_DEF);
      ld_q        <= '0;
      r_q         <= '0;
      c_q         <= '0;
      q_q         <= '0;
      t_q         <= '0;
      unm_q       <= '0;
      guard_q     <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      ld_q        <= ld_d;
      r_q         <= r_d;
      c_q         <= c_d;
      q_q         <= q_d;
      t_q         <= t_d;
      unm_q       <= unm_d;
      guard_q     <= guard_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ar_q       <= ar_d;
    ac_q       <= ac_d;
    prev_q     <= prev_d;
    s_q        <= s_d;
    red_q      <= red_d;
    base_q     <= base_d;
    tot_q      <= tot_d;
    mn_q       <= mn_d;
    pp_q       <= pp_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_tot_q  <= out_tot_d;
    out_fail_q <= out_fail_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign row_index_o       = out_row_q;
  assign assigned_column_o = out_col_q;
  assign total_cost_o      = out_tot_q;
  assign check_failed_o    = out_fail_q;
  assign last_result_o     = out_last_q;

endmodule

`default_nettype wire
